// File: hdl/ptc_pkg.sv
// Package for the barometric pressure and temperature compensation pipeline.
// Holds register indexes, fixed constants and shared arithmetic helpers.
// No dependencies.
`default_nettype none
package ptc_pkg;

	localparam int IDX_W  = 3;
	localparam int DATA_W = 32;
	localparam int DIV_W  = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2   = 3'd3,
		REG_MC_MD   = 3'd4,
		REG_OSS     = 3'd5
	} reg_idx_t;

	localparam logic [31:0] B6_OFFSET   = 32'd4000;
	localparam logic [31:0] B4_OFFSET   = 32'd32768;
	localparam logic [15:0] P_SCALE     = 16'd50000;
	localparam logic [31:0] P_K1        = 32'd3038;
	localparam logic [31:0] P_K2        = 32'hFFFF_E343;
	localparam logic [31:0] P_K3        = 32'd3791;
	localparam logic [19:0] PRESS_MAX   = 20'hF_FFFF;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	function automatic logic [15:0] sat_temp(input logic [31:0] v);
		logic [15:0] r;
		if ($signed(v) > 32'sd32767)
			r = 16'h7FFF;
		else if ($signed(v) < -32'sd32768)
			r = 16'h8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic [19:0] sat_press(input logic [31:0] v);
		logic [19:0] r;
		if (v[31])
			r = '0;
		else if (v > {12'd0, PRESS_MAX})
			r = PRESS_MAX;
		else
			r = v[19:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/pressure_temperature_compensation.sv
// Throughput: one item per cycle; two 32-stage restoring dividers set the depth.
// The whole pipeline holds when the output register is full and not taken.
// Reset: arst_n clears valid bits and calibration registers; payload is not reset.
// Depends on ptc_pkg.
`default_nettype none
module pressure_temperature_compensation (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [ptc_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [ptc_pkg::DATA_W-1:0]   wr_data,
	input  wire logic                         raw_valid,
	output logic                              raw_ready,
	input  wire logic [15:0]                  raw_temp,
	input  wire logic [23:0]                  raw_pressure,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic signed [15:0]                temperature,
	output logic [19:0]                       pressure,
	output logic                              status
);
	import ptc_pkg::*;

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_AC1_AC2: ac12_q <= wr_data;
				REG_AC3_AC4: ac34_q <= wr_data;
				REG_AC5_AC6: ac56_q <= wr_data;
				REG_B1_B2:   b12_q  <= wr_data;
				REG_MC_MD:   mcmd_q <= wr_data;
				REG_OSS:     oss_q  <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(ac12_q[31:16]);
	assign ac2 = sx16(ac12_q[15:0]);
	assign ac3 = sx16(ac34_q[31:16]);
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = sx16(b12_q[31:16]);
	assign b2  = sx16(b12_q[15:0]);
	assign mc  = sx16(mcmd_q[31:16]);
	assign md  = sx16(mcmd_q[15:0]);

	logic adv;
	assign adv       = !res_valid || res_ready;
	assign raw_ready = adv;

	// stage 1
	logic        v_s1;
	logic [31:0] prod_s1;
	logic [23:0] up_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= raw_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= ({16'd0, raw_temp} - ac6) * ac5;
			up_s1   <= raw_pressure >> (4'd8 - {2'd0, oss_q});
		end
	end

	// temperature divider
	logic [31:0] x1t, dt, numt;
	assign x1t  = asr(prod_s1, 5'd15);
	assign dt   = x1t + md;
	assign numt = mc << 11;

	logic        da_v   [0:DIV_W];
	logic [31:0] da_rem [0:DIV_W];
	logic [31:0] da_num [0:DIV_W];
	logic [31:0] da_den [0:DIV_W];
	logic [31:0] da_x1  [0:DIV_W];
	logic [23:0] da_up  [0:DIV_W];
	logic        da_neg [0:DIV_W];
	logic        da_zt  [0:DIV_W];
	logic [32:0] da_sh  [0:DIV_W-1];
	logic [32:0] da_sub [0:DIV_W-1];

	always_comb begin
		for (int k = 0; k < DIV_W; k++) begin
			da_sh[k]  = {da_rem[k], da_num[k][31]};
			da_sub[k] = da_sh[k] - {1'b0, da_den[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_W; k++) da_v[k] <= 1'b0;
		end else if (adv) begin
			da_v[0] <= v_s1;
			for (int k = 0; k < DIV_W; k++) da_v[k+1] <= da_v[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da_rem[0] <= '0;
			da_num[0] <= numt[31] ? 32'(-numt) : numt;
			da_den[0] <= dt[31] ? 32'(-dt) : dt;
			da_x1[0]  <= x1t;
			da_up[0]  <= up_s1;
			da_neg[0] <= numt[31] ^ dt[31];
			da_zt[0]  <= (dt == '0);
			for (int k = 0; k < DIV_W; k++) begin
				da_rem[k+1] <= da_sub[k][32] ? da_sh[k][31:0] : da_sub[k][31:0];
				da_num[k+1] <= {da_num[k][30:0], !da_sub[k][32]};
				da_den[k+1] <= da_den[k];
				da_x1[k+1]  <= da_x1[k];
				da_up[k+1]  <= da_up[k];
				da_neg[k+1] <= da_neg[k];
				da_zt[k+1]  <= da_zt[k];
			end
		end
	end

	// stage 3
	logic [31:0] x2t, b5;
	assign x2t = da_neg[DIV_W] ? 32'(-da_num[DIV_W]) : da_num[DIV_W];
	assign b5  = da_x1[DIV_W] + x2t;

	logic        v_s3, zt_s3;
	logic [31:0] b6_s3;
	logic [15:0] t_s3;
	logic [23:0] up_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= da_v[DIV_W];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3  <= sat_temp(asr(b5 + 32'd8, 5'd4));
			b6_s3 <= b5 - B6_OFFSET;
			up_s3 <= da_up[DIV_W];
			zt_s3 <= da_zt[DIV_W];
		end
	end

	// stage 4
	logic        v_s4, zt_s4;
	logic [31:0] mbb_s4, mac2_s4, mac3_s4;
	logic [15:0] t_s4;
	logic [23:0] up_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mbb_s4  <= b6_s3 * b6_s3;
			mac2_s4 <= ac2 * b6_s3;
			mac3_s4 <= ac3 * b6_s3;
			t_s4    <= t_s3;
			up_s4   <= up_s3;
			zt_s4   <= zt_s3;
		end
	end

	// stage 5
	logic [31:0] sq;
	assign sq = asr(mbb_s4, 5'd12);

	logic        v_s5, zt_s5;
	logic [31:0] msqb2_s5, mb1sq_s5, x2a_s5, x1c_s5;
	logic [15:0] t_s5;
	logic [23:0] up_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			msqb2_s5 <= sq * b2;
			mb1sq_s5 <= b1 * sq;
			x2a_s5   <= asr(mac2_s4, 5'd11);
			x1c_s5   <= asr(mac3_s4, 5'd13);
			t_s5     <= t_s4;
			up_s5    <= up_s4;
			zt_s5    <= zt_s4;
		end
	end

	// stage 6
	logic [31:0] x3a, b3v, x3bv;
	assign x3a  = asr(msqb2_s5, 5'd11) + x2a_s5;
	assign b3v  = asr((((ac1 << 2) + x3a) << oss_q) + 32'd2, 5'd2);
	assign x3bv = asr(x1c_s5 + asr(mb1sq_s5, 5'd16) + 32'd2, 5'd2);

	logic        v_s6, zt_s6;
	logic [31:0] b3_s6, x3b_s6;
	logic [15:0] t_s6;
	logic [23:0] up_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s6  <= b3v;
			x3b_s6 <= x3bv;
			t_s6   <= t_s5;
			up_s6  <= up_s5;
			zt_s6  <= zt_s5;
		end
	end

	// stage 7
	logic        v_s7, zt_s7;
	logic [31:0] mb4_s7, diff_s7;
	logic [15:0] t_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mb4_s7  <= ac4 * (x3b_s6 + B4_OFFSET);
			diff_s7 <= {8'd0, up_s6} - b3_s6;
			t_s7    <= t_s6;
			zt_s7   <= zt_s6;
		end
	end

	// pressure divider
	logic [31:0] b4v, b7v, scale;
	assign scale = {16'd0, P_SCALE >> oss_q};
	assign b4v   = mb4_s7 >> 15;
	assign b7v   = diff_s7 * scale;

	logic        db_v   [0:DIV_W];
	logic [31:0] db_rem [0:DIV_W];
	logic [31:0] db_num [0:DIV_W];
	logic [31:0] db_den [0:DIV_W];
	logic [15:0] db_t   [0:DIV_W];
	logic        db_big [0:DIV_W];
	logic        db_z   [0:DIV_W];
	logic [32:0] db_sh  [0:DIV_W-1];
	logic [32:0] db_sub [0:DIV_W-1];

	always_comb begin
		for (int k = 0; k < DIV_W; k++) begin
			db_sh[k]  = {db_rem[k], db_num[k][31]};
			db_sub[k] = db_sh[k] - {1'b0, db_den[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_W; k++) db_v[k] <= 1'b0;
		end else if (adv) begin
			db_v[0] <= v_s7;
			for (int k = 0; k < DIV_W; k++) db_v[k+1] <= db_v[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			db_rem[0] <= '0;
			db_num[0] <= b7v[31] ? b7v : (b7v << 1);
			db_den[0] <= b4v;
			db_t[0]   <= t_s7;
			db_big[0] <= b7v[31];
			db_z[0]   <= zt_s7 || (b4v == '0);
			for (int k = 0; k < DIV_W; k++) begin
				db_rem[k+1] <= db_sub[k][32] ? db_sh[k][31:0] : db_sub[k][31:0];
				db_num[k+1] <= {db_num[k][30:0], !db_sub[k][32]};
				db_den[k+1] <= db_den[k];
				db_t[k+1]   <= db_t[k];
				db_big[k+1] <= db_big[k];
				db_z[k+1]   <= db_z[k];
			end
		end
	end

	// stage 9
	logic [31:0] pq, x1p;
	assign pq  = db_big[DIV_W] ? (db_num[DIV_W] << 1) : db_num[DIV_W];
	assign x1p = asr(pq, 5'd8);

	logic        v_s9, z_s9;
	logic [31:0] p_s9, mx_s9, mk2_s9;
	logic [15:0] t_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= db_v[DIV_W];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9   <= pq;
			mx_s9  <= x1p * x1p;
			mk2_s9 <= pq * P_K2;
			t_s9   <= db_t[DIV_W];
			z_s9   <= db_z[DIV_W];
		end
	end

	// stage 10
	logic        v_s10, z_s10;
	logic [31:0] p_s10, mk1_s10, x2p_s10;
	logic [15:0] t_s10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (adv) v_s10 <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s10   <= p_s9;
			mk1_s10 <= mx_s9 * P_K1;
			x2p_s10 <= asr(mk2_s9, 5'd16);
			t_s10   <= t_s9;
			z_s10   <= z_s9;
		end
	end

	// output register
	logic [31:0] pfin;
	assign pfin = p_s10 + asr(asr(mk1_s10, 5'd16) + x2p_s10 + P_K3, 5'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (adv) res_valid <= v_s10;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			temperature <= z_s10 ? '0 : t_s10;
			pressure    <= z_s10 ? '0 : sat_press(pfin);
			status      <= z_s10;
		end
	end

`ifndef ASSERT_OFF
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status |-> temperature == '0 && pressure == '0)
		else $error("flagged result carries non-zero fields");

	a_diva_rem: assert property (@(posedge clk) disable iff (!arst_n)
		da_v[DIV_W] && da_den[DIV_W] != '0 |-> da_rem[DIV_W] < da_den[DIV_W])
		else $error("temperature divider remainder not below divisor");

	a_divb_rem: assert property (@(posedge clk) disable iff (!arst_n)
		db_v[DIV_W] && db_den[DIV_W] != '0 |-> db_rem[DIV_W] < db_den[DIV_W])
		else $error("pressure divider remainder not below divisor");
`endif

endmodule
`default_nettype wire
